// ----- rtl/uifcm_pkg.sv -----
// ----------------------------------------------------------------------------
// uifcm_pkg: shared types and constants of the UART command matcher
// Action and command codes, command text lookup.
// ----------------------------------------------------------------------------
package uifcm_pkg;

    typedef logic [1:0] action_t;
    typedef logic [1:0] command_t;

    localparam action_t ACT_BYTE   = 2'd0;
    localparam action_t ACT_TICK   = 2'd1;
    localparam action_t ACT_BUTTON = 2'd2;

    localparam command_t CMD_NONE = 2'd0;
    localparam command_t CMD_USER = 2'd1;
    localparam command_t CMD_BOOT = 2'd2;

    // "command: reboot" is a prefix of "command: reboot bootloader"
    localparam logic [4:0] USER_LEN = 5'd15;
    localparam logic [4:0] BOOT_LEN = 5'd26;

    localparam logic [15:0] IDLE_LIMIT_RESET = 16'd100;

    // Character of the long command at a position; NUL past its end.
    function automatic logic [7:0] cmd_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0:    c = "c";
            5'd1:    c = "o";
            5'd2:    c = "m";
            5'd3:    c = "m";
            5'd4:    c = "a";
            5'd5:    c = "n";
            5'd6:    c = "d";
            5'd7:    c = ":";
            5'd8:    c = " ";
            5'd9:    c = "r";
            5'd10:   c = "e";
            5'd11:   c = "b";
            5'd12:   c = "o";
            5'd13:   c = "o";
            5'd14:   c = "t";
            5'd15:   c = " ";
            5'd16:   c = "b";
            5'd17:   c = "o";
            5'd18:   c = "o";
            5'd19:   c = "t";
            5'd20:   c = "l";
            5'd21:   c = "o";
            5'd22:   c = "a";
            5'd23:   c = "d";
            5'd24:   c = "e";
            5'd25:   c = "r";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/uart_idle_framed_command_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// uart_idle_framed_command_matcher_unit: idle-timed UART command matcher
// Result on m_ the cycle after input; one transaction per cycle while s_ready is high.
// s_ready drops only while a result waits in the output register and m_ready is low.
// Reset (aresetn, sync, active low): frame cleared, timer stopped, idle_limit 100.
// ----------------------------------------------------------------------------
module uart_idle_framed_command_matcher_unit #(
    parameter int MAX_LEN = 29
) (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration: idle_limit
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,

    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_rx_byte,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_command,
    output logic [4:0]  m_frame_bytes
);

    localparam logic [4:0] MaxLenW = 5'(MAX_LEN);

    // ---------------- registers ----------------
    logic [15:0] idle_limit_reg;
    logic [15:0] idle_count_reg,    idle_count_next;
    logic        timer_running_reg, timer_running_next;
    logic [4:0]  kept_length_reg,   kept_length_next;
    logic        string_ended_reg,  string_ended_next;
    logic [4:0]  text_length_reg,   text_length_next;
    logic        match_user_reg,    match_user_next;
    logic        match_boot_reg,    match_boot_next;

    logic                  m_valid_reg,   m_valid_next;
    uifcm_pkg::command_t   m_command_reg, m_command_next;
    logic [4:0]            m_bytes_reg,   m_bytes_next;

    // Accept whenever the output register is free or being emptied.
    logic s_fire;
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // ---------------- per-transaction update ----------------
    logic [15:0] idle_inc;
    logic [7:0]  exp_char;
    assign idle_inc = (idle_count_reg == 16'hFFFF) ? idle_count_reg : idle_count_reg + 16'd1;
    assign exp_char = uifcm_pkg::cmd_char(text_length_reg);

    always_comb begin
        idle_count_next    = idle_count_reg;
        timer_running_next = timer_running_reg;
        kept_length_next   = kept_length_reg;
        string_ended_next  = string_ended_reg;
        text_length_next   = text_length_reg;
        match_user_next    = match_user_reg;
        match_boot_next    = match_boot_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_command_next     = m_command_reg;
        m_bytes_next       = m_bytes_reg;

        if (s_fire) begin
            case (uifcm_pkg::action_t'(s_action))
                uifcm_pkg::ACT_BYTE: begin
                    timer_running_next = 1'b1;
                    idle_count_next    = 16'd0;
                    if (kept_length_reg < MaxLenW) begin
                        kept_length_next = kept_length_reg + 5'd1;
                        if (!string_ended_reg) begin
                            if (s_rx_byte == 8'h00) begin
                                string_ended_next = 1'b1;
                            end else begin
                                // a byte past a command's length clears its match; the table
                                // gives NUL past its end, which never equals a non-NUL byte
                                if (!(text_length_reg < uifcm_pkg::USER_LEN
                                      && exp_char == s_rx_byte))
                                    match_user_next = 1'b0;
                                if (!(text_length_reg < uifcm_pkg::BOOT_LEN
                                      && exp_char == s_rx_byte))
                                    match_boot_next = 1'b0;
                                text_length_next = text_length_reg + 5'd1;
                            end
                        end
                    end
                end
                uifcm_pkg::ACT_BUTTON: begin
                    m_valid_next   = 1'b1;
                    m_command_next = uifcm_pkg::CMD_BOOT;
                    m_bytes_next   = 5'd0;
                end
                uifcm_pkg::ACT_TICK: begin
                    if (timer_running_reg) begin
                        idle_count_next = idle_inc;
                        if (idle_inc > idle_limit_reg) begin
                            // frame closes; report only if something was kept
                            timer_running_next = 1'b0;
                            idle_count_next    = 16'd0;
                            kept_length_next   = 5'd0;
                            string_ended_next  = 1'b0;
                            text_length_next   = 5'd0;
                            match_user_next    = 1'b1;
                            match_boot_next    = 1'b1;
                            if (kept_length_reg != 5'd0) begin
                                m_valid_next = 1'b1;
                                m_bytes_next = kept_length_reg;
                                if (match_boot_reg && text_length_reg == uifcm_pkg::BOOT_LEN)
                                    m_command_next = uifcm_pkg::CMD_BOOT;
                                else if (match_user_reg
                                         && text_length_reg == uifcm_pkg::USER_LEN)
                                    m_command_next = uifcm_pkg::CMD_USER;
                                else
                                    m_command_next = uifcm_pkg::CMD_NONE;
                            end
                        end
                    end
                end
                default: begin
                    // unused action code: no effect
                end
            endcase
        end
    end

    // ---------------- state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_limit_reg    <= uifcm_pkg::IDLE_LIMIT_RESET;
            idle_count_reg    <= 16'd0;
            timer_running_reg <= 1'b0;
            kept_length_reg   <= 5'd0;
            string_ended_reg  <= 1'b0;
            text_length_reg   <= 5'd0;
            match_user_reg    <= 1'b1;
            match_boot_reg    <= 1'b1;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                idle_limit_reg <= cfg_wdata;
            end
            idle_count_reg    <= idle_count_next;
            timer_running_reg <= timer_running_next;
            kept_length_reg   <= kept_length_next;
            string_ended_reg  <= string_ended_next;
            text_length_reg   <= text_length_next;
            match_user_reg    <= match_user_next;
            match_boot_reg    <= match_boot_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // result payload: no reset needed
    always_ff @(posedge aclk) begin
        m_command_reg <= m_command_next;
        m_bytes_reg   <= m_bytes_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_command     = m_command_reg;
    assign m_frame_bytes = m_bytes_reg;

`ifndef NO_ASSERTIONS
    // Stopped timer means no frame in progress.
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !timer_running_reg |-> (idle_count_reg == 16'd0 && kept_length_reg == 5'd0))
        else $error("stopped timer with live frame state");

    // Text never outgrows kept bytes, which never exceed the limit.
    a_len_order: assert property (@(posedge aclk) disable iff (!aresetn)
        text_length_reg <= kept_length_reg && kept_length_reg <= MaxLenW)
        else $error("frame length counters out of order");

    // Button press yields a bootloader result with no bytes next cycle.
    a_button: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_action == uifcm_pkg::ACT_BUTTON) |=>
            (m_valid && m_command == uifcm_pkg::CMD_BOOT && m_frame_bytes == 5'd0))
        else $error("button press not reported");

    // A closed-frame result always carries at least one byte.
    a_frame_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_action == uifcm_pkg::ACT_TICK && m_valid_next && !m_valid_reg)
            |-> (m_bytes_next != 5'd0))
        else $error("empty frame reported");
`endif

endmodule
